// ===== rtl/fwr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwr_pkg
// Shared types and constants of the queue with remove-by-match.
// ----------------------------------------------------------------------------
package fwr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int ACT_W     = 2;
    localparam int CNT_OUT_W = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REM = 2'd2;

    // read address select (logical positions)
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_LAST = 2'd1;
    localparam logic [1:0] RD_PREV = 2'd2;
    localparam logic [1:0] RD_NEXT = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       enq_wr;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       idx_ld_last;
        logic       idx_dec;
        logic       idx_inc;
        logic       shift_wr;
        logic       head_inc;
        logic       count_inc;
        logic       count_dec;
        logic       set_rej;
        logic       set_hit_deq;
        logic       set_hit_rem;
        logic       load_out;
    } fwr_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             empty;
        logic             match;
        logic             idx_zero;
        logic             idx_last;
        logic             next_last;
        logic             out_busy;
    } fwr_stat_t;

endpackage

// ===== rtl/fwr_ram.sv =====
// ----------------------------------------------------------------------------
// fwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/fwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwr_ctrl
// Sequencer: decodes the item, walks the search and gap closing.
// ----------------------------------------------------------------------------
module fwr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fwr_pkg::fwr_stat_t stat,
    output fwr_pkg::fwr_cmd_t  cmd
);
    import fwr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_DQ    = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SH_RD = 3'd4;
    localparam logic [2:0] ST_SH_WR = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_FIN;
                case (stat.act)
                    ACT_ENQ: begin
                        if (stat.full) begin
                            cmd.set_rej = 1'b1;
                        end else begin
                            cmd.enq_wr    = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                    end
                    ACT_DEQ: begin
                        if (!stat.empty) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            state_next = ST_DQ;
                        end
                    end
                    ACT_REM: begin
                        if (!stat.empty) begin
                            cmd.rd_en       = 1'b1;
                            cmd.rd_sel      = RD_LAST;
                            cmd.idx_ld_last = 1'b1;
                            state_next      = ST_SCAN;
                        end
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_DQ: begin
                cmd.set_hit_deq = 1'b1;
                cmd.head_inc    = 1'b1;
                cmd.count_dec   = 1'b1;
                state_next      = ST_FIN;
            end
            ST_SCAN: begin
                if (stat.match) begin
                    cmd.set_hit_rem = 1'b1;
                    if (stat.idx_last) begin
                        cmd.count_dec = 1'b1;
                        state_next    = ST_FIN;
                    end else begin
                        state_next = ST_SH_RD;
                    end
                end else if (stat.idx_zero) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_PREV;
                    cmd.idx_dec = 1'b1;
                end
            end
            ST_SH_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = ST_SH_WR;
            end
            ST_SH_WR: begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                if (stat.next_last) begin
                    cmd.count_dec = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    state_next = ST_SH_RD;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/fwr_dp.sv =====
// ----------------------------------------------------------------------------
// fwr_dp
// Datapath: circular entry store, pointers, compare and result register.
// ----------------------------------------------------------------------------
module fwr_dp #(
    parameter int DEPTH = fwr_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [fwr_pkg::ACT_W-1:0]         s_action,
    input  logic [fwr_pkg::WORD_W-1:0]        s_data_word,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [fwr_pkg::WORD_W-1:0]        m_result_word,
    output logic                              m_hit,
    output logic                              m_full_reject,
    output logic [fwr_pkg::CNT_OUT_W-1:0]     m_entry_count,
    input  fwr_pkg::fwr_cmd_t                 cmd,
    output fwr_pkg::fwr_stat_t                stat
);
    import fwr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [ACT_W-1:0]  act_reg;
    logic [WORD_W-1:0] word_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     idx_reg;
    logic [WORD_W-1:0] res_reg;
    logic              hit_reg;
    logic              rej_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_hit_reg;
    logic              out_rej_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic [AW-1:0]     last_idx;
    logic [AW-1:0]     rd_log, wr_log;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data, rdata;
    logic [CW:0]       idx_ext;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign last_idx = AW'(count_reg - CW'(1));
    assign idx_ext  = (CW+1)'(idx_reg);

    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO: rd_log = '0;
            RD_LAST: rd_log = last_idx;
            RD_PREV: rd_log = idx_reg - AW'(1);
            RD_NEXT: rd_log = idx_reg + AW'(1);
            default: rd_log = '0;
        endcase
    end

    assign wr_log  = cmd.shift_wr ? idx_reg : AW'(count_reg);
    assign rd_addr = phys(head_reg, rd_log);
    assign wr_addr = phys(head_reg, wr_log);
    assign wr_data = cmd.shift_wr ? rdata : word_reg;

    fwr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.enq_wr | cmd.shift_wr),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.head_inc) begin
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= s_action;
            word_reg <= s_data_word;
            res_reg  <= '0;
            hit_reg  <= 1'b0;
            rej_reg  <= 1'b0;
        end
        if (cmd.set_rej) begin
            rej_reg <= 1'b1;
        end
        if (cmd.set_hit_deq) begin
            res_reg <= rdata;
            hit_reg <= 1'b1;
        end
        if (cmd.set_hit_rem) begin
            res_reg <= word_reg;
            hit_reg <= 1'b1;
        end
        if (cmd.idx_ld_last) begin
            idx_reg <= last_idx;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - AW'(1);
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.load_out) begin
            out_word_reg <= res_reg;
            out_hit_reg  <= hit_reg;
            out_rej_reg  <= rej_reg;
            out_cnt_reg  <= cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign cnt_ext = (CW+CNT_OUT_W)'(count_reg);

    assign stat.act       = act_reg;
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.match     = (rdata == word_reg);
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.idx_last  = ((idx_ext + (CW+1)'(1)) == (CW+1)'(count_reg));
    assign stat.next_last = ((idx_ext + (CW+1)'(2)) == (CW+1)'(count_reg));
    assign stat.out_busy  = out_valid_reg & ~m_ready;

    assign m_valid       = out_valid_reg;
    assign m_result_word = out_word_reg;
    assign m_hit         = out_hit_reg;
    assign m_full_reject = out_rej_reg;
    assign m_entry_count = out_cnt_reg;
endmodule

// ===== rtl/fifo_with_remove_by_match_core.sv =====
// Flow: enqueue goes through dispatch and finish; dequeue adds a read state; remove
//   compares entries from the newest end, then moves each newer entry down one slot.
// Throughput: one item at a time; next accept in the cycle after the result loads. The
//   sequencer walks the single RAM read port: one compare a cycle, read+write per shift.
// Reset (aresetn low, synchronous): queue empty, head at slot 0, no result pending.
//   Store contents are not cleared; slots beyond the count are never read.
// ----------------------------------------------------------------------------
// fifo_with_remove_by_match_core
// Ordered word queue with enqueue, dequeue oldest and remove newest match.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_match_core #(
    parameter int DEPTH = fwr_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fwr_pkg::ACT_W-1:0]     s_action,
    input  logic [fwr_pkg::WORD_W-1:0]    s_data_word,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fwr_pkg::WORD_W-1:0]    m_result_word,
    output logic                          m_hit,
    output logic                          m_full_reject,
    output logic [fwr_pkg::CNT_OUT_W-1:0] m_entry_count
);
    import fwr_pkg::*;

    fwr_cmd_t  cmd;
    fwr_stat_t stat;

    // Sequencer: one item in flight; the result register lets the next item
    // be taken while the previous result still waits on m_ready.
    fwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: circular store (head pointer makes dequeue a pointer bump),
    // newest-first scan for remove, then newer entries slide down one slot.
    fwr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_data_word   (s_data_word),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_word (m_result_word),
        .m_hit         (m_hit),
        .m_full_reject (m_full_reject),
        .m_entry_count (m_entry_count),
        .cmd           (cmd),
        .stat          (stat)
    );
endmodule

// ===== verif/fwr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwr_checker
// Watches both channels, predicts each result from a queue model, compares.
// ----------------------------------------------------------------------------
module fwr_checker #(
    parameter int DEPTH = fwr_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [fwr_pkg::ACT_W-1:0]     s_action,
    input  logic [fwr_pkg::WORD_W-1:0]    s_data_word,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [fwr_pkg::WORD_W-1:0]    m_result_word,
    input  logic                          m_hit,
    input  logic                          m_full_reject,
    input  logic [fwr_pkg::CNT_OUT_W-1:0] m_entry_count,
    output int                            fail_count,
    output int                            pending_count,
    output int                            held_count
);
    import fwr_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]    word;
        logic                 hit;
        logic                 rej;
        logic [CNT_OUT_W-1:0] count;
    } queue_result_t;

    logic [WORD_W-1:0] model_q[$];
    queue_result_t     result_q[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        held_count    = 0;
    end

    function automatic queue_result_t apply_request(logic [ACT_W-1:0] act,
                                                    logic [WORD_W-1:0] w);
        queue_result_t r;
        r = '0;
        case (act)
            ACT_ENQ: begin
                if (model_q.size() < DEPTH) model_q.push_back(w);
                else r.rej = 1'b1;
            end
            ACT_DEQ: begin
                if (model_q.size() > 0) begin
                    r.word = model_q.pop_front();
                    r.hit  = 1'b1;
                end
            end
            ACT_REM: begin
                for (int k = model_q.size() - 1; k >= 0; k--) begin
                    if (model_q[k] == w) begin
                        r.word = w;
                        r.hit  = 1'b1;
                        model_q.delete(k);
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.count = CNT_OUT_W'(model_q.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_result_t e;
        int            errs;
        errs = 0;
        if (aresetn && s_valid && s_ready)
            result_q.push_back(apply_request(s_action, s_data_word));
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("result with nothing expected");
                errs++;
            end else begin
                e = result_q.pop_front();
                if (m_result_word !== e.word) begin
                    $error("result_word expected %h actual %h", e.word, m_result_word);
                    errs++;
                end
                if (m_hit !== e.hit) begin
                    $error("hit expected %b actual %b", e.hit, m_hit);
                    errs++;
                end
                if (m_full_reject !== e.rej) begin
                    $error("full_reject expected %b actual %b", e.rej, m_full_reject);
                    errs++;
                end
                if (m_entry_count !== e.count) begin
                    $error("entry_count expected %0d actual %0d", e.count, m_entry_count);
                    errs++;
                end
            end
        end
        if (errs != 0)
            fail_count <= fail_count + errs;
        pending_count <= result_q.size();
        held_count    <= model_q.size();
    end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Queue with remove-by-match: directed corners, then random request mixes
// under several idle and stall patterns; a side checker scores every result.
// ----------------------------------------------------------------------------
module testbench;
    import fwr_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int CYCLE_CAP = 400000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ACT_W-1:0]     s_action = ACT_ENQ;
    logic [WORD_W-1:0]    s_data_word = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WORD_W-1:0]    m_result_word;
    logic                 m_hit;
    logic                 m_full_reject;
    logic [CNT_OUT_W-1:0] m_entry_count;

    int fail_count, pending_count, held_count;
    int send_idle_pct = 0;   // chance per cycle the sender holds back
    int recv_stall_pct = 0;  // chance per cycle the receiver stalls
    int cycle_count = 0;

    // small value pool so removes actually find duplicates and matches
    logic [WORD_W-1:0] pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h1,
                                   32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF, 32'h5A5A_A5A5};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fifo_with_remove_by_match_core #(.DEPTH(DEPTH)) dut (.*);

    fwr_checker #(.DEPTH(DEPTH)) chk (.*);

    // receiver back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one item: optional idle gap, then hold valid until accepted;
    // valid drops in the next call or in drain
    task automatic send_item(logic [ACT_W-1:0] act, logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // random request: mostly well-formed, with words from the pool or fully random
    task automatic send_random();
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] w;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 3) act = ACT_UNUSED;
        else if (pick < 45 - (held_count > 12 ? 25 : 0)) act = ACT_ENQ;
        else if (pick < 70) act = ACT_DEQ;
        else act = ACT_REM;
        w = ($urandom_range(3) == 0) ? $urandom : pool[$urandom_range(7)];
        send_item(act, w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty corners, duplicates, overflow, unused code
        send_item(ACT_DEQ, 32'h0);
        send_item(ACT_REM, 32'hFFFF_FFFF);
        send_item(ACT_UNUSED, 32'hFFFF_FFFF);
        send_item(ACT_ENQ, 32'hFFFF_FFFF);
        send_item(ACT_ENQ, 32'h0);
        send_item(ACT_ENQ, 32'hFFFF_FFFF);
        send_item(ACT_REM, 32'hFFFF_FFFF);   // newest duplicate goes
        send_item(ACT_REM, 32'h1234_5678);   // no match
        send_item(ACT_DEQ, 32'h0);
        send_item(ACT_DEQ, 32'h0);
        for (int i = 0; i < DEPTH + 1; i++)  // fill plus one refused
            send_item(ACT_ENQ, 32'hC000_0000 | i);
        send_item(ACT_REM, 32'hC000_0000);   // oldest, whole queue shifts
        send_item(ACT_REM, 32'hC000_0000 | (DEPTH - 1)); // newest

        // pause until everything is back
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 76) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 76) : 0;
            for (int i = 0; i < 100; i++) send_random();
        end

        recv_stall_pct = 0;
        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
